### hw/rtl/cle_pkg.sv
// Shared types, constants and codes of the canonical line editor.
package cle_pkg;

  localparam int unsigned LINE_MAX   = 256;
  localparam int unsigned LINE_W     = $clog2(LINE_MAX);
  localparam int unsigned STORE_DEPTH = 2 * LINE_MAX;
  localparam int unsigned STORE_AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_DEL = 8'd127;

  typedef enum logic [1:0] {
    REQ_KEY    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_LINE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_CANON      = 3'd0,
    CFG_ECHO       = 3'd1,
    CFG_ERASE_ECHO = 3'd2,
    CFG_CR_TO_NL   = 3'd3,
    CFG_ERASE_CHAR = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_ERASE_ECHO,
    CMD_ECHO,
    CMD_ECHO_LINE,
    CMD_LINE,
    CMD_READ,
    CMD_EMPTY
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       canon;
    logic       echo;
    logic       erase_echo;
    logic       cr_to_nl;
    logic [7:0] erase_char;
  } cfg_t;

endpackage

### hw/rtl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cle_front.sv
// Front end: accepts requests, edits line and queue state, issues commands.
module cle_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cle_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    key_char_i,
  input  logic [cle_pkg::CMDQ_CW-1:0]   q_count_i,
  output logic                          push_o,
  output cle_pkg::cmd_t                 push_cmd_o
);
  import cle_pkg::*;

  logic                accept;
  logic                bank_q, bank_d;
  logic [LINE_W-1:0]   len_q, len_d;
  logic [LINE_W:0]     qlen_q, qlen_d;
  logic [LINE_W:0]     qpos_q, qpos_d;
  logic [LINE_W:0]     qpos_inc;
  logic                stg_valid_q, stg_valid_d;
  cmd_t                stg_cmd_q, stg_cmd_d;
  logic [7:0]          c;
  logic [7:0]          erase;
  logic                printable;
  logic                mem_we;
  logic [STORE_AW-1:0] mem_waddr;
  logic [7:0]          mem_wdata;
  logic                mem_re;
  logic [STORE_AW-1:0] mem_raddr;
  logic [7:0]          mem_rdata;

  assign in_ready_o = (q_count_i + CMDQ_CW'(stg_valid_q)) < CMDQ_CW'(CMDQ_DEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign c          = (key_char_i == CH_CR && cfg_i.cr_to_nl) ? CH_NL : key_char_i;
  assign erase      = (cfg_i.erase_char == CH_NUL) ? CH_DEL : cfg_i.erase_char;
  assign printable  = (c == CH_CR) || (c == CH_TAB) || (c >= CH_SP);
  assign qpos_inc   = qpos_q + 1'b1;

  always_comb begin
    bank_d      = bank_q;
    len_d       = len_q;
    qlen_d      = qlen_q;
    qpos_d      = qpos_q;
    stg_valid_d = 1'b0;
    stg_cmd_d   = '{op: CMD_ECHO, data: c};
    mem_we      = 1'b0;
    mem_waddr   = {bank_q, len_q};
    mem_wdata   = c;
    mem_re      = 1'b0;
    mem_raddr   = {~bank_q, qpos_q[LINE_W-1:0]};
    if (accept) begin
      case (req_type_i)
        REQ_KEY: begin
          if (c == CH_NUL) begin
            stg_valid_d = 1'b0;
          end else if (!cfg_i.canon) begin
            if (cfg_i.echo && (c == CH_BS || c == CH_DEL)) begin
              stg_valid_d = 1'b1;
              stg_cmd_d.op = CMD_ERASE_ECHO;
            end else if (cfg_i.echo && (printable || c == CH_NL)) begin
              stg_valid_d = 1'b1;
            end
          end else if (c == CH_BS || c == CH_DEL || c == erase) begin
            if (len_q != '0) begin
              len_d = len_q - 1'b1;
              stg_valid_d = cfg_i.echo && cfg_i.erase_echo;
              stg_cmd_d.op = CMD_ERASE_ECHO;
            end
          end else if (c == CH_NL) begin
            mem_we       = 1'b1;
            qlen_d       = {1'b0, len_q} + 1'b1;
            qpos_d       = '0;
            len_d        = '0;
            bank_d       = ~bank_q;
            stg_valid_d  = 1'b1;
            stg_cmd_d.op = cfg_i.echo ? CMD_ECHO_LINE : CMD_LINE;
          end else if (len_q != LINE_W'(LINE_MAX - 1)) begin
            mem_we      = 1'b1;
            len_d       = len_q + 1'b1;
            stg_valid_d = cfg_i.echo && printable;
          end
        end
        REQ_READ: begin
          stg_valid_d = 1'b1;
          if (qpos_q >= qlen_q) begin
            qlen_d       = '0;
            qpos_d       = '0;
            stg_cmd_d.op = CMD_EMPTY;
          end else begin
            mem_re       = 1'b1;
            stg_cmd_d.op = CMD_READ;
            if (qpos_inc >= qlen_q) begin
              qlen_d = '0;
              qpos_d = '0;
            end else begin
              qpos_d = qpos_inc;
            end
          end
        end
        REQ_FLUSH: begin
          len_d  = '0;
          qlen_d = '0;
          qpos_d = '0;
        end
        default: begin
          stg_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      len_q       <= '0;
      qlen_q      <= '0;
      qpos_q      <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      bank_q      <= bank_d;
      len_q       <= len_d;
      qlen_q      <= qlen_d;
      qpos_q      <= qpos_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_cmd_q <= stg_cmd_d;
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign push_o          = stg_valid_q;
  assign push_cmd_o.op   = stg_cmd_q.op;
  assign push_cmd_o.data = (stg_cmd_q.op == CMD_READ) ? mem_rdata : stg_cmd_q.data;

endmodule

### hw/rtl/cle_cmd_fifo.sv
// Short command queue between front end and back end.
module cle_cmd_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  cle_pkg::cmd_t               push_cmd_i,
  input  logic                        pop_i,
  output cle_pkg::cmd_t               head_o,
  output logic                        empty_o,
  output logic [cle_pkg::CMDQ_CW-1:0] count_o
);
  import cle_pkg::*;

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_q, wr_d;
  logic [CMDQ_PW-1:0] rd_q, rd_d;
  logic [CMDQ_CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CMDQ_CW'(push_i) - CMDQ_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

### hw/rtl/cle_back.sv
// Back end: expands commands into result transactions through an output register.
module cle_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cle_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    data_byte_o,
  output logic          last_o
);
  import cle_pkg::*;

  logic [1:0] step_q, step_d;
  logic       valid_q, valid_d;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  kind_e      res_kind;
  logic [7:0] res_byte;
  logic       res_last;

  assign load = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    res_kind = KIND_ECHO;
    res_byte = head_i.data;
    res_last = 1'b1;
    case (head_i.op)
      CMD_ERASE_ECHO: begin
        res_byte = (step_q == 2'd1) ? CH_SP : CH_BS;
        res_last = (step_q == 2'd2);
      end
      CMD_ECHO: begin
        res_byte = head_i.data;
      end
      CMD_ECHO_LINE: begin
        res_kind = (step_q == 2'd0) ? KIND_ECHO : KIND_LINE;
        res_byte = (step_q == 2'd0) ? CH_NL : 8'd0;
        res_last = (step_q != 2'd0);
      end
      CMD_LINE: begin
        res_kind = KIND_LINE;
        res_byte = 8'd0;
      end
      CMD_READ: begin
        res_kind = KIND_READ;
      end
      CMD_EMPTY: begin
        res_kind = KIND_EMPTY;
        res_byte = 8'd0;
      end
      default: begin
        res_byte = 8'd0;
      end
    endcase
  end

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      kind_d  = res_kind;
      byte_d  = res_byte;
      last_d  = res_last;
      step_d  = res_last ? 2'd0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign pop_o       = load && res_last;
  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = byte_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/canonical_line_editor_unit.sv
// Top level of the canonical line editor: configuration registers and front/back ends.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  request  | in_valid_i/in_ready_o  | req_type_i, key_char_i
//  result   | out_valid_o/out_ready_i| kind_o, data_byte_o, last_o
//  config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One request is accepted per cycle while the four-entry command queue has room.
// Results leave at one per cycle from the output register while out_ready_i is high;
// a request yields 0 to 3 results, the first passing the staging register, command
// queue and output register. Reset clears counters and queue; the 512-byte line
// store needs no clearing pass. Each side stalls independently through the queue.
module canonical_line_editor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] key_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import cle_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [CMDQ_CW-1:0] q_count;
  logic               push;
  cmd_t               push_cmd;
  logic               pop;
  cmd_t               head;
  logic               empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANON:      cfg_d.canon      = cfg_data_i[0];
        CFG_ECHO:       cfg_d.echo       = cfg_data_i[0];
        CFG_ERASE_ECHO: cfg_d.erase_echo = cfg_data_i[0];
        CFG_CR_TO_NL:   cfg_d.cr_to_nl   = cfg_data_i[0];
        CFG_ERASE_CHAR: cfg_d.erase_char = cfg_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{canon: 1'b1, echo: 1'b1, erase_echo: 1'b1, cr_to_nl: 1'b1,
                 erase_char: CH_DEL};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .key_char_i (key_char_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  cle_cmd_fifo u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .count_o    (q_count)
  );

  cle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

endmodule

### verif/tb.sv
// Testbench for the canonical line editor: result prediction, random traffic and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned PHASE_COUNT = 10;
  localparam int unsigned PHASE_ITEMS = 4;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  class editor_scoreboard;
    cfg_t          cfg;
    logic [7:0]    line_store [STORE_DEPTH];
    bit            active_bank;
    int unsigned   line_len;
    int unsigned   queue_len;
    int unsigned   queue_pos;
    result_t       due_results [$];
    int unsigned   mismatches;

    function new();
      cfg = '{canon: 1'b1, echo: 1'b1, erase_echo: 1'b1, cr_to_nl: 1'b1, erase_char: CH_DEL};
      active_bank = 1'b0;
      line_len = 0;
      queue_len = 0;
      queue_pos = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] val);
      case (idx)
        CFG_CANON:      cfg.canon = val[0];
        CFG_ECHO:       cfg.echo = val[0];
        CFG_ERASE_ECHO: cfg.erase_echo = val[0];
        CFG_CR_TO_NL:   cfg.cr_to_nl = val[0];
        CFG_ERASE_CHAR: cfg.erase_char = val;
        default: ;
      endcase
    endfunction

    function void push_result(kind_e kind, logic [7:0] data);
      due_results.push_back('{kind: kind, data: data, last: 1'b0});
    endfunction

    function void push_erase_echo();
      push_result(KIND_ECHO, CH_BS);
      push_result(KIND_ECHO, CH_SP);
      push_result(KIND_ECHO, CH_BS);
    endfunction

    function void predict_request(logic [1:0] req, logic [7:0] key);
      int unsigned n_prior;
      logic [7:0]  c;
      logic [7:0]  erase_code;
      n_prior = due_results.size();
      erase_code = (cfg.erase_char == CH_NUL) ? CH_DEL : cfg.erase_char;
      c = (key == CH_CR && cfg.cr_to_nl) ? CH_NL : key;
      case (req)
        REQ_KEY: begin
          if (c == CH_NUL) begin
          end else if (!cfg.canon) begin
            if (cfg.echo) begin
              if (c == CH_BS || c == CH_DEL) begin
                push_erase_echo();
              end else if (c == CH_CR || c == CH_NL || c == CH_TAB || c >= CH_SP) begin
                push_result(KIND_ECHO, c);
              end
            end
          end else if (c == CH_BS || c == CH_DEL || c == erase_code) begin
            if (line_len > 0) begin
              line_len--;
              if (cfg.echo && cfg.erase_echo) push_erase_echo();
            end
          end else if (c == CH_NL) begin
            if (cfg.echo) push_result(KIND_ECHO, CH_NL);
            line_store[int'(active_bank) * LINE_MAX + line_len] = CH_NL;
            queue_len = line_len + 1;
            queue_pos = 0;
            line_len = 0;
            active_bank = !active_bank;
            push_result(KIND_LINE, CH_NUL);
          end else if (line_len + 1 < LINE_MAX) begin
            line_store[int'(active_bank) * LINE_MAX + line_len] = c;
            line_len++;
            if (cfg.echo && (c == CH_CR || c == CH_TAB || c >= CH_SP)) push_result(KIND_ECHO, c);
          end
        end
        REQ_READ: begin
          if (queue_pos >= queue_len) begin
            queue_len = 0;
            queue_pos = 0;
            push_result(KIND_EMPTY, CH_NUL);
          end else begin
            push_result(KIND_READ, line_store[int'(!active_bank) * LINE_MAX + queue_pos]);
            queue_pos++;
            if (queue_pos >= queue_len) begin
              queue_len = 0;
              queue_pos = 0;
            end
          end
        end
        REQ_FLUSH: begin
          line_len = 0;
          queue_len = 0;
          queue_pos = 0;
        end
        default: ;
      endcase
      if (due_results.size() > n_prior) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d data %0d last %0d", kind, data, last));
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind || data !== want.data || last !== want.last) begin
          report($sformatf("expected kind %0d data %0d last %0d, got kind %0d data %0d last %0d",
                           want.kind, want.data, want.last, kind, data, last));
        end
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] req_type_i;
  logic [7:0] key_char_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] kind_o;
  logic [7:0] data_byte_o;
  logic       last_o;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  editor_scoreboard sb = new();

  bit          idle_on;
  bit          rx_hold_go;
  int unsigned rx_hold_left;
  int unsigned items_sent;
  int unsigned cycle_count;
  cfg_t        phase_cfg [PHASE_COUNT];

  canonical_line_editor_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .key_char_i  (key_char_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: check at the rising edge, drive ready at the falling edge.
  initial begin
    out_ready_i = 1'b0;
    rx_hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(kind_o, data_byte_o, last_o);
      @(negedge clk_i);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        rx_hold_left = 150;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = !(idle_on && $urandom_range(0, 99) < 22);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(logic [1:0] req, logic [7:0] key);
    while (idle_on && $urandom_range(0, 99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = req;
    key_char_i = key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_request(req, key);
    if (req != REQ_UNUSED && !(req == REQ_KEY && key == CH_NUL)) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_CANON, {7'd0, c.canon});
    write_reg(CFG_ECHO, {7'd0, c.echo});
    write_reg(CFG_ERASE_ECHO, {7'd0, c.erase_echo});
    write_reg(CFG_CR_TO_NL, {7'd0, c.cr_to_nl});
    write_reg(CFG_ERASE_CHAR, c.erase_char);
  endtask

  function automatic logic [7:0] line_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 58) return 8'($urandom_range(32, 126));
    if (r < 70) return 8'($urandom_range(128, 255));
    if (r < 75) return CH_TAB;
    if (r < 81) return 8'($urandom_range(1, 31));
    if (r < 87) return CH_BS;
    if (r < 93) return CH_DEL;
    return sb.cfg.erase_char;
  endfunction

  task automatic run_phase(int unsigned target);
    int unsigned r;
    int unsigned len;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(0, 10);
        repeat (len) send_item(REQ_KEY, line_byte());
        r = $urandom_range(0, 99);
        if (r < 45) send_item(REQ_KEY, CH_NL);
        else if (r < 80) send_item(REQ_KEY, CH_CR);
        repeat ($urandom_range(0, len + 2)) send_item(REQ_READ, 8'($urandom_range(0, 255)));
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) send_item(REQ_READ, 8'($urandom_range(0, 255)));
      end else if (r < 80) begin
        send_item(REQ_FLUSH, 8'($urandom_range(0, 255)));
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_KEY;
    key_char_i = CH_NUL;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CANON;
    cfg_data_i = 8'd0;
    idle_on = 1'b1;
    rx_hold_go = 1'b0;
    items_sent = 0;
    phase_cfg[0] = '{1'b1, 1'b1, 1'b1, 1'b1, 8'd0};
    phase_cfg[1] = '{1'b1, 1'b1, 1'b1, 1'b1, 8'd255};
    phase_cfg[2] = '{1'b1, 1'b1, 1'b0, 1'b0, CH_NL};
    phase_cfg[3] = '{1'b1, 1'b0, 1'b1, 1'b1, CH_CR};
    phase_cfg[4] = '{1'b0, 1'b1, 1'b1, 1'b1, CH_DEL};
    phase_cfg[5] = '{1'b0, 1'b0, 1'b0, 1'b0, 8'd0};
    phase_cfg[6] = '{1'b0, 1'b1, 1'b1, 1'b0, 8'd65};
    phase_cfg[7] = '{1'b1, 1'b1, 1'b1, 1'b1, 8'($urandom_range(1, 255))};
    phase_cfg[8] = '{1'b1, 1'b1, 1'b1, 1'b0, 8'($urandom_range(1, 255))};
    phase_cfg[9] = '{1'b1, 1'b1, 1'b0, 1'b1, 8'd97};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    apply_config('{1'b1, 1'b1, 1'b1, 1'b1, 8'd0});
    send_item(REQ_READ, 8'd0);
    send_item(REQ_KEY, CH_NUL);
    send_item(REQ_KEY, 8'd65);
    send_item(REQ_KEY, 8'd255);
    send_item(REQ_KEY, CH_SP);
    send_item(REQ_KEY, CH_TAB);
    send_item(REQ_KEY, 8'd1);
    send_item(REQ_KEY, CH_BS);
    send_item(REQ_KEY, CH_DEL);
    send_item(REQ_KEY, CH_CR);
    repeat (5) send_item(REQ_READ, 8'hff);
    send_item(REQ_KEY, CH_NL);
    send_item(REQ_KEY, CH_BS);
    send_item(REQ_FLUSH, 8'hff);
    send_item(REQ_READ, 8'h00);
    send_item(REQ_UNUSED, 8'hff);
    send_item(REQ_KEY, 8'd126);
    send_item(REQ_KEY, 8'd31);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      apply_config(phase_cfg[p]);
      if (p == 0) begin
        idle_on = 1'b0;
        // overfill one line, then commit it and read the head back
        repeat ($urandom_range(258, 262)) send_item(REQ_KEY, 8'($urandom_range(32, 126)));
        send_item(REQ_KEY, CH_NL);
        repeat (4) send_item(REQ_READ, 8'($urandom_range(0, 255)));
        wait_idle();
        rx_hold_go = 1'b1;
        repeat (16) send_item(REQ_KEY, 8'($urandom_range(32, 126)));
        wait_idle();
        idle_on = 1'b1;
        items_sent = 0;
      end
      run_phase(items_sent + PHASE_ITEMS);
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### canonical_line_editor_unit.f
hw/rtl/cle_pkg.sv
hw/rtl/cle_ram.sv
hw/rtl/cle_front.sv
hw/rtl/cle_cmd_fifo.sv
hw/rtl/cle_back.sv
hw/rtl/canonical_line_editor_unit.sv
verif/tb.sv
